[sv/ltc_pkg.sv]
// ============================================================================
// ltc_pkg: shared types and constants of the line token classifier
// Holds the token classes, the character constants, the recognizer states,
// the per-line state and result structs with the line reset value, and the character and accepting-state functions.
// ============================================================================
`default_nettype none

package ltc_pkg;

    // Token classes as they appear on the result channel.
    localparam logic [2:0] CLS_ID  = 3'd0;
    localparam logic [2:0] CLS_NUM = 3'd1;
    localparam logic [2:0] CLS_STR = 3'd2;
    localparam logic [2:0] CLS_COM = 3'd3;
    localparam logic [2:0] CLS_UNK = 3'd4;

    // Characters that steer the recognizers.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_TILDE      = 8'h7E;

    typedef enum logic [3:0] {
        ST_START     = 4'd0,
        ST_ID_BODY   = 4'd1,
        ST_ID_UNDER  = 4'd2,
        ST_ID_TAIL   = 4'd3,
        ST_NUM_INT   = 4'd4,
        ST_NUM_ZERO  = 4'd5,
        ST_NUM_DOT   = 4'd6,
        ST_NUM_FRAC  = 4'd7,
        ST_STR_BODY  = 4'd8,
        ST_STR_ESC   = 4'd9,
        ST_STR_DONE  = 4'd10,
        ST_COM_OPEN  = 4'd11,
        ST_COM_BODY  = 4'd12,
        ST_COM_SLASH = 4'd13,
        ST_COM_DONE  = 4'd14,
        ST_FAIL      = 4'd15
    } t_dfa_state;

    typedef struct packed {
        t_dfa_state dfa_state;
        logic [2:0] line_class;
        logic [7:0] char_count;
        logic       at_line_start;
    } t_line_state;

    typedef struct packed {
        logic [2:0] token_class;
        logic       token_valid;
        logic [7:0] token_length;
    } t_token;

    localparam t_line_state LINE_RESET = '{
        dfa_state:     ST_START,
        line_class:    CLS_ID,
        char_count:    8'd0,
        at_line_start: 1'b1
    };

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || is_digit(c);
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return c >= CH_SPACE && c <= CH_TILDE;
    endfunction

    function automatic logic is_accepting(input t_dfa_state s);
        return s == ST_ID_BODY || s == ST_ID_TAIL || s == ST_NUM_INT ||
               s == ST_NUM_ZERO || s == ST_NUM_FRAC || s == ST_STR_DONE ||
               s == ST_COM_DONE;
    endfunction

endpackage

`default_nettype wire

[sv/ltc_if.sv]
// ============================================================================
// ltc_if: handshake channels of the line token classifier
// One channel carries input bytes, the other carries token results.
// ============================================================================
`default_nettype none

interface ltc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface ltc_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_class;
    logic       token_valid;
    logic [7:0] token_length;

    modport source (output valid, output token_class, output token_valid,
                    output token_length, input ready);
    modport sink (input valid, input token_class, input token_valid,
                  input token_length, output ready);
endinterface

`default_nettype wire

[sv/ltc_step.sv]
// ============================================================================
// ltc_step: one recognizer step
// Combinational transition of the per-line state for one byte, and the
// token result that a line terminator produces.
// ============================================================================
`default_nettype none

module ltc_step #(
    parameter int LEN_CAP = 255
) (
    input  ltc_pkg::t_line_state i_line,
    input  logic [7:0]           i_byte,
    output ltc_pkg::t_line_state o_line,
    output logic                 o_emit,
    output ltc_pkg::t_token      o_token
);
    import ltc_pkg::*;

    localparam logic [8:0] CAP = 9'(LEN_CAP);

    t_dfa_state w_nx;
    logic [1:0] w_add;
    logic [8:0] w_sum;
    logic       w_term;
    logic       w_ok;

    assign w_term = (i_byte == CH_NUL) || (i_byte == CH_LF);
    assign w_ok   = is_accepting(i_line.dfa_state);

    // Transition of the recognizer that runs past the first byte.
    always_comb begin
        w_nx  = ST_FAIL;
        w_add = 2'd0;
        unique case (i_line.dfa_state)
            ST_ID_BODY: begin
                if (is_alnum(i_byte)) begin
                    w_nx = ST_ID_BODY; w_add = 2'd1;
                end else if (i_byte == CH_UNDERSCORE) begin
                    w_nx = ST_ID_UNDER; w_add = 2'd1;
                end
            end
            ST_ID_UNDER, ST_ID_TAIL: begin
                if (is_alnum(i_byte)) begin
                    w_nx = ST_ID_TAIL; w_add = 2'd1;
                end
            end
            ST_NUM_INT: begin
                if (is_digit(i_byte)) begin
                    w_nx = ST_NUM_INT; w_add = 2'd1;
                end else if (i_byte == CH_DOT) begin
                    w_nx = ST_NUM_DOT; w_add = 2'd1;
                end
            end
            ST_NUM_ZERO: begin
                if (i_byte == CH_DOT) begin
                    w_nx = ST_NUM_DOT; w_add = 2'd1;
                end
            end
            ST_NUM_DOT, ST_NUM_FRAC: begin
                if (is_digit(i_byte)) begin
                    w_nx = ST_NUM_FRAC; w_add = 2'd1;
                end
            end
            ST_STR_BODY: begin
                if (i_byte == CH_QUOTE) begin
                    w_nx = ST_STR_DONE;
                end else if (i_byte == CH_BACKSLASH) begin
                    w_nx = ST_STR_ESC; w_add = 2'd1;
                end else if (is_print(i_byte)) begin
                    w_nx = ST_STR_BODY; w_add = 2'd1;
                end
            end
            ST_STR_ESC: begin
                if (is_print(i_byte)) begin
                    w_nx = ST_STR_BODY; w_add = 2'd1;
                end
            end
            ST_COM_OPEN: begin
                if (i_byte == CH_SLASH) begin
                    w_nx = ST_COM_BODY;
                end
            end
            ST_COM_BODY: begin
                if (i_byte == CH_SLASH) begin
                    w_nx = ST_COM_SLASH;
                end else begin
                    w_nx = ST_COM_BODY; w_add = 2'd1;
                end
            end
            ST_COM_SLASH: begin
                // A lone slash inside the comment is counted together with the
                // following byte once that byte shows it did not close.
                if (i_byte == CH_SLASH) begin
                    w_nx = ST_COM_DONE;
                end else begin
                    w_nx = ST_COM_BODY; w_add = 2'd2;
                end
            end
            default: begin
                // The start state past line start, the done states, and the
                // fail state all fail on any further byte.
                w_nx = ST_FAIL;
            end
        endcase
    end

    assign w_sum = {1'b0, i_line.char_count} + {7'd0, w_add};

    always_comb begin
        o_line  = i_line;
        o_emit  = 1'b0;
        o_token = '{token_class: CLS_UNK, token_valid: 1'b0, token_length: 8'd0};
        if (w_term) begin
            o_emit = 1'b1;
            o_line = LINE_RESET;
            if (!i_line.at_line_start) begin
                o_token.token_class  = i_line.line_class;
                o_token.token_valid  = w_ok;
                o_token.token_length = w_ok ? i_line.char_count : 8'd0;
            end
        end else if (i_line.at_line_start) begin
            o_line.at_line_start = 1'b0;
            o_line.char_count    = 8'd0;
            if (is_letter(i_byte)) begin
                o_line.line_class = CLS_ID;
                o_line.dfa_state  = ST_ID_BODY;
                o_line.char_count = 8'd1;
            end else if (i_byte == CH_ZERO) begin
                o_line.line_class = CLS_NUM;
                o_line.dfa_state  = ST_NUM_ZERO;
                o_line.char_count = 8'd1;
            end else if (is_digit(i_byte)) begin
                o_line.line_class = CLS_NUM;
                o_line.dfa_state  = ST_NUM_INT;
                o_line.char_count = 8'd1;
            end else if (i_byte == CH_QUOTE) begin
                o_line.line_class = CLS_STR;
                o_line.dfa_state  = ST_STR_BODY;
            end else if (i_byte == CH_SLASH) begin
                o_line.line_class = CLS_COM;
                o_line.dfa_state  = ST_COM_OPEN;
            end else begin
                o_line.line_class = CLS_UNK;
                o_line.dfa_state  = ST_FAIL;
            end
        end else if (i_line.dfa_state != ST_FAIL) begin
            o_line.dfa_state = w_nx;
            if (w_nx != ST_FAIL) begin
                o_line.char_count = (w_sum > CAP) ? CAP[7:0] : w_sum[7:0];
            end
        end
    end

endmodule

`default_nettype wire

[sv/line_token_classifier.sv]
// ============================================================================
// line_token_classifier: per-line lexical token recognizer
// Classifies each terminated line of a byte stream as identifier, number,
// string or comment and reports whether it matched and how long it is.
// ============================================================================
//
// Usage: bytes enter on i_byte, one item per byte. A byte of 0 or 10 ends
// the current line; every other byte produces no result. Each terminator
// produces exactly one item on o_token carrying the class, a match flag and
// the token length (zero when the line did not match).
//
// Each byte is first captured in an input register. From there the
// recognizer step updates the line state and, for a terminator, loads the
// result register that drives o_token. One byte can be accepted in
// every cycle for as long as the result channel keeps up.
//
// When the receiver stalls with a result pending, the block keeps taking
// bytes that do not end a line; a terminator waits in the input register
// until the result register frees up, and i_byte.ready stays low while it
// waits. That is the only case in which i_byte.ready drops.
//
// Reset (synchronous, active low) empties both registers and returns the
// line state to line start with a zero count.
//
// Lengths saturate at the smaller of LINE_BUFFER-1 and 255.
`default_nettype none

module line_token_classifier #(
    parameter int LINE_BUFFER = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltc_byte_if.sink    i_byte,
    ltc_token_if.source o_token
);
    import ltc_pkg::*;

    localparam int LEN_CAP = (LINE_BUFFER - 1 > 255) ? 255 : LINE_BUFFER - 1;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Per-line recognizer state.
    t_line_state r_line;
    t_line_state n_line;

    // Result register.
    logic        r_out_valid;
    t_token      r_out;
    t_token      n_out;

    logic        w_emit;
    logic        w_out_free;
    logic        w_proc;
    logic        w_in_ready;

    ltc_step #(
        .LEN_CAP (LEN_CAP)
    ) u_step (
        .i_line  (r_line),
        .i_byte  (r_in_byte),
        .o_line  (n_line),
        .o_emit  (w_emit),
        .o_token (n_out)
    );

    // The held byte moves on unless it is a terminator and the result
    // register is still occupied by a result nobody has taken.
    assign w_out_free = !r_out_valid || o_token.ready;
    assign w_proc     = r_in_valid && (!w_emit || w_out_free);
    assign w_in_ready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_line      <= LINE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_proc) begin
                r_line <= n_line;
            end
            if (w_proc && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_token.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
        end
        if (w_proc && w_emit) begin
            r_out <= n_out;
        end
    end

    assign i_byte.ready         = w_in_ready;
    assign o_token.valid        = r_out_valid;
    assign o_token.token_class  = r_out.token_class;
    assign o_token.token_valid  = r_out.token_valid;
    assign o_token.token_length = r_out.token_length;

endmodule

`default_nettype wire

[sv/ltc_checker.sv]
// ============================================================================
// ltc_checker: port-level checks of the line token classifier
// Watches the result channel and the reset, and is bound to the top level.
// ============================================================================
`default_nettype none

module ltc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_token_class,
    input logic       i_token_valid,
    input logic [7:0] i_token_length
);
    import ltc_pkg::*;

    // A pending result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A line that did not match reports a zero length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_token_valid |-> i_token_length == 8'd0)
        else $error("nonzero length on an unmatched line");

    // An unknown first character never gives a match.
    a_unk_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_token_class == CLS_UNK |-> !i_token_valid)
        else $error("unknown class reported as matched");

    // Only the five defined classes ever appear.
    a_cls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_token_class <= CLS_UNK)
        else $error("token class out of range");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind line_token_classifier ltc_checker u_ltc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_token.valid),
    .i_out_ready    (o_token.ready),
    .i_token_class  (o_token.token_class),
    .i_token_valid  (o_token.token_valid),
    .i_token_length (o_token.token_length)
);

`default_nettype wire
